/* hw/rtl/edsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsp_pkg
// Shared types and constants for the encoder-driven stepper positioner.
// ----------------------------------------------------------------------------
package edsp_pkg;

  // Default width of the encoder count
  localparam int EDSP_COUNT_WIDTH = 16;

  // Register reset values
  localparam logic [7:0] GAIN_RESET   = 8'd5;
  localparam logic [7:0] COARSE_RESET = 8'd10;

  // Register indexes (byte address bit 2)
  localparam logic REG_TARGET_GAIN = 1'b0;
  localparam logic REG_COARSE_INC  = 1'b1;

  // Button bit positions (active low)
  localparam int BTN_CLEAR = 0;
  localparam int BTN_MODE1 = 1;
  localparam int BTN_MODE2 = 2;
  localparam int BTN_MODE3 = 3;

  // Mode codes; the motor runs only in MODE_RUN
  localparam logic [1:0] MODE_RUN = 2'd0;
  localparam logic [1:0] MODE_1   = 2'd1;
  localparam logic [1:0] MODE_2   = 2'd2;
  localparam logic [1:0] MODE_3   = 2'd3;

  // Configuration registers as seen by the core
  typedef struct packed {
    logic [7:0] target_gain;
    logic [7:0] coarse_increment;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic       step_strobe;
    logic [3:0] buttons_n;
    logic       coarse_switch_n;
    logic       dt_pin;
    logic       clk_pin;
  } item_t;

  // One result item
  typedef struct packed {
    logic [1:0]         mode_value;
    logic signed [15:0] motor_position;
    logic signed [15:0] target_position;
    logic [7:0]         led_value;
    logic [3:0]         coil_drive;
  } result_t;

endpackage

/* hw/rtl/encoder_driven_stepper_positioner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_driven_stepper_positioner_top
// Stepper positioner driven by a rotary encoder, buttons and a step strobe.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per pin sample (encoder CLK/DT, coarse switch, buttons,
//           step strobe). Accepted when in_tvalid and in_tready are high.
//   out_* : one result item per input item, in order: coils, LED latch,
//           target, position and mode after that sample.
//   cfg_* : APB port; target_gain at 0x0, coarse_increment at 0x4.
// Timing: an accepted item sits in the input register, is processed by one
//   pass of logic (count add, 16x8 gain multiply, signed compare) and lands
//   in the output register once that is empty or being taken, which raises
//   out_tvalid. One item per cycle is sustained while out_tready stays high.
// Stall: when out_tready is low the output register holds its result and
//   the input register takes one more item, then in_tready drops until the
//   output is taken. Nothing is lost or repeated.
// Reset (rst_n low, synchronous): both registers empty, state cleared,
//   gain 5, coarse increment 10. Write configuration only while idle.
// ----------------------------------------------------------------------------
module encoder_driven_stepper_positioner_top
  import edsp_pkg::*;
#(
  parameter int COUNT_WIDTH = EDSP_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: clk_pin[0], dt_pin[1], coarse_switch_n[2], buttons_n[6:3],
  //           step_strobe[7]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: coil_drive[3:0], led_value[11:4], target_position[27:12],
  //            motor_position[43:28], mode_value[45:44], zero[47:46]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_valid_r;
  result_t result;
  result_t result_r;
  logic    out_valid_r;
  logic    process;
  logic    in_accept;

  edsp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Pipeline handshake
  assign process   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || process;
  assign in_accept = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (process) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= item_t'(in_tdata);
    end
  end

  edsp_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (process),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, result_r};

endmodule

/* hw/rtl/edsp_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsp_cfg_regs
// APB register file holding the target gain and the coarse increment.
// ----------------------------------------------------------------------------
module edsp_cfg_regs
  import edsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  logic       reg_idx;
  logic       wr_en;
  logic [7:0] gain_r;
  logic [7:0] coarse_r;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      coarse_r <= COARSE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET_GAIN: gain_r   <= cfg_pwdata[7:0];
        REG_COARSE_INC:  coarse_r <= cfg_pwdata[7:0];
        default:         gain_r   <= gain_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_TARGET_GAIN: cfg_prdata = {24'd0, gain_r};
      REG_COARSE_INC:  cfg_prdata = {24'd0, coarse_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.target_gain      = gain_r;
  assign cfg.coarse_increment = coarse_r;

endmodule

/* hw/rtl/edsp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsp_core
// Positioner state and its single-pass update: buttons, encoder, motor step.
// ----------------------------------------------------------------------------
module edsp_core
  import edsp_pkg::*;
#(
  parameter int COUNT_WIDTH = EDSP_COUNT_WIDTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  // State
  logic                   last_clk_r;
  logic [3:0]             last_btn_r;
  logic [COUNT_WIDTH-1:0] count_r,    count_nxt;
  logic [15:0]            target_r,   target_nxt;
  logic [15:0]            position_r, position_nxt;
  logic [1:0]             phase_r,    phase_nxt;
  logic [3:0]             coil_r,     coil_nxt;
  logic [7:0]             led_r,      led_nxt;
  logic [1:0]             mode_r,     mode_nxt;

  // Intermediates
  logic                   btn_chg;
  logic                   clk_chg;
  logic [COUNT_WIDTH-1:0] count_btn;
  logic [COUNT_WIDTH-1:0] delta;
  logic [15:0]            target_btn;
  logic [15:0]            cnt16;
  logic [23:0]            product;

  // Update for one item
  always_comb begin
    btn_chg    = item.buttons_n != last_btn_r;
    clk_chg    = item.clk_pin != last_clk_r;
    mode_nxt   = mode_r;
    count_btn  = count_r;
    position_nxt = position_r;
    target_btn = target_r;

    // Buttons, only on a change of pattern; later button wins
    if (btn_chg) begin
      if (!item.buttons_n[BTN_CLEAR]) begin
        mode_nxt     = MODE_RUN;
        count_btn    = '0;
        position_nxt = 16'd0;
        target_btn   = 16'd0;
      end
      if (!item.buttons_n[BTN_MODE1]) mode_nxt = MODE_1;
      if (!item.buttons_n[BTN_MODE2]) mode_nxt = MODE_2;
      if (!item.buttons_n[BTN_MODE3]) mode_nxt = MODE_3;
    end

    // Encoder: falling CLK moves the count
    delta     = item.coarse_switch_n ? COUNT_WIDTH'(1)
                                     : COUNT_WIDTH'(cfg.coarse_increment);
    count_nxt = count_btn;
    if (clk_chg && !item.clk_pin) begin
      count_nxt = item.dt_pin ? (count_btn - delta) : (count_btn + delta);
    end

    // On a CLK change the target becomes the sign-extended count times the gain, kept to 16 bits
    cnt16   = 16'($signed(count_nxt));
    product = 24'(cnt16) * 24'(cfg.target_gain);
    led_nxt    = clk_chg ? count_nxt[7:0] : led_r;
    target_nxt = clk_chg ? product[15:0] : target_btn;

    // Motor step toward the target
    coil_nxt  = coil_r;
    phase_nxt = phase_r;
    if (item.step_strobe && mode_nxt == MODE_RUN) begin
      if ($signed(target_nxt) > $signed(position_nxt)) begin
        coil_nxt     = 4'b0001 << phase_r;
        position_nxt = position_nxt + 16'd1;
        phase_nxt    = phase_r + 2'd1;
      end else if ($signed(target_nxt) < $signed(position_nxt)) begin
        coil_nxt     = 4'b0001 << phase_r;
        position_nxt = position_nxt - 16'd1;
        phase_nxt    = phase_r - 2'd1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_clk_r <= 1'b1;
      last_btn_r <= 4'hF;
      count_r    <= '0;
      target_r   <= 16'd0;
      position_r <= 16'd0;
      phase_r    <= 2'd0;
      coil_r     <= 4'd0;
      led_r      <= 8'd0;
      mode_r     <= MODE_RUN;
    end else if (fire) begin
      last_clk_r <= item.clk_pin;
      last_btn_r <= item.buttons_n;
      count_r    <= count_nxt;
      target_r   <= target_nxt;
      position_r <= position_nxt;
      phase_r    <= phase_nxt;
      coil_r     <= coil_nxt;
      led_r      <= led_nxt;
      mode_r     <= mode_nxt;
    end
  end

  // Result is the state after this item
  assign result.coil_drive      = coil_nxt;
  assign result.led_value       = led_nxt;
  assign result.target_position = target_nxt;
  assign result.motor_position  = position_nxt;
  assign result.mode_value      = mode_nxt;

`ifndef SYNTHESIS
  // No item, no state change
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r) && $stable(position_r) && $stable(phase_r)
              && $stable(mode_r))
    else $error("core state moved without an item");

  // Motor stays put outside run mode unless the buttons changed
  a_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    fire && mode_r != MODE_RUN && item.buttons_n == last_btn_r
      |=> position_r == $past(position_r))
    else $error("motor moved outside run mode");

  // Every phase change drives exactly one coil
  a_phase_coil: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_nxt != phase_r |=> $onehot(coil_r))
    else $error("phase advanced without a one-hot coil");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the encoder-driven stepper positioner. Pin samples
// go in as directed cases and then as random detent, button and strobe
// sequences. They run under several gain and coarse settings, with random
// gaps on both streams and one long output hold-off. A tracker class
// predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import edsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_SEGMENT = 47;

  // --------------------------------------------------------------------------
  // Predicts the positioner state after each pin sample, holds the expected
  // result items and checks the block's output against them
  // --------------------------------------------------------------------------
  class stepper_position_tracker;
    logic [7:0]         gain = GAIN_RESET;
    logic [7:0]         coarse = COARSE_RESET;
    logic               last_clk = 1'b1;
    logic [3:0]         last_btn = 4'hF;
    logic [15:0]        count = '0;
    logic signed [15:0] target = '0;
    logic signed [15:0] position = '0;
    logic [1:0]         phase = '0;
    logic [3:0]         coil = '0;
    logic [7:0]         led = '0;
    logic [1:0]         mode = MODE_RUN;
    result_t            expected_states[$];
    int                 mismatches = 0;
    int                 checked = 0;

    function void set_register(logic idx, logic [7:0] value);
      if (idx == REG_TARGET_GAIN) begin
        gain = value;
      end else begin
        coarse = value;
      end
    endfunction

    function void note_sample(item_t s);
      logic [15:0] delta;
      result_t     r;
      // buttons only act on a change of pattern; later buttons win
      if (s.buttons_n != last_btn) begin
        if (!s.buttons_n[BTN_CLEAR]) begin
          mode = MODE_RUN;
          count = '0;
          target = '0;
          position = '0;
        end
        if (!s.buttons_n[BTN_MODE1]) mode = MODE_1;
        if (!s.buttons_n[BTN_MODE2]) mode = MODE_2;
        if (!s.buttons_n[BTN_MODE3]) mode = MODE_3;
        last_btn = s.buttons_n;
      end
      // encoder: falling CLK moves the count, any CLK edge updates latches
      if (s.clk_pin != last_clk) begin
        if (!s.clk_pin) begin
          delta = s.coarse_switch_n ? 16'd1 : {8'h00, coarse};
          count = s.dt_pin ? count - delta : count + delta;
        end
        led = count[7:0];
        target = count * {8'h00, gain};
      end
      last_clk = s.clk_pin;
      // wave drive: one step toward the target per strobe in run mode
      if (s.step_strobe && mode == MODE_RUN) begin
        if (target > position) begin
          coil = 4'b0001 << phase;
          position = position + 16'sd1;
          phase = phase + 2'd1;
        end else if (target < position) begin
          coil = 4'b0001 << phase;
          position = position - 16'sd1;
          phase = phase - 2'd1;
        end
      end
      r.coil_drive = coil;
      r.led_value = led;
      r.target_position = target;
      r.motor_position = position;
      r.mode_value = mode;
      expected_states.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [47:0] data);
      result_t got;
      result_t exp_r;
      got = data[45:0];
      if (expected_states.size() == 0) begin
        mismatches++;
        $display("%0t: result %h with no item pending, expected none", $realtime, data);
        return;
      end
      exp_r = expected_states.pop_front();
      checked++;
      compare_field("coil_drive", exp_r.coil_drive, got.coil_drive);
      compare_field("led_value", exp_r.led_value, got.led_value);
      compare_field("target_position", exp_r.target_position, got.target_position);
      compare_field("motor_position", exp_r.motor_position, got.motor_position);
      compare_field("mode_value", exp_r.mode_value, got.mode_value);
      compare_field("padding", 16'h0, data[47:46]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // clk_pin, dt_pin, coarse_switch_n, buttons_n, step_strobe
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;          // coil_drive, led_value, target, position, mode, zero pad
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  stepper_position_tracker tracker = new();

  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_cycles = 0;
  int items_sent = 0;
  int settings_run = 0;

  // current pin levels, so random sequences form proper detents
  logic       pin_clk = 1'b1;
  logic [3:0] pin_btn = 4'hF;

  encoder_driven_stepper_positioner_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  // offer one pin sample, with random idle cycles ahead of it
  task automatic send_sample(input logic clk_v, input logic dt_v, input logic coarse_v,
                             input logic [3:0] btn_v, input logic strobe_v);
    item_t s;
    s.clk_pin = clk_v;
    s.dt_pin = dt_v;
    s.coarse_switch_n = coarse_v;
    s.buttons_n = btn_v;
    s.step_strobe = strobe_v;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= s;
    do @(posedge clk); while (!in_tready);
    tracker.note_sample(s);
    items_sent++;
    pin_clk = clk_v;
    pin_btn = btn_v;
  endtask

  // stop offering and let every pending result drain
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.expected_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write followed by a read-back
  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'h0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'h0, value}) begin
      tracker.mismatches++;
      $display("%0t: register %0d read-back, expected %h, actual %h",
               $realtime, idx, {24'h0, value}, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  // random pin activity: mostly encoder detents with strobes, some button
  // presses, and a little pure noise
  task automatic run_random(input int n);
    int         roll;
    logic [3:0] btn;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    4'($urandom_range(15)), 1'($urandom_range(1)));
      end else if (roll < 16) begin
        roll = $urandom_range(99);
        if (roll < 35) btn = 4'hF;
        else if (roll < 65) btn = 4'hE;
        else if (roll < 85) btn = ~(4'b0001 << $urandom_range(1, 3));
        else btn = 4'($urandom_range(15));
        send_sample(pin_clk, 1'($urandom_range(1)), 1'b1, btn, 1'($urandom_range(1)));
      end else begin
        send_sample(($urandom_range(99) < 60) ? ~pin_clk : pin_clk, 1'($urandom_range(1)),
                    $urandom_range(99) >= 25, pin_btn, $urandom_range(99) < 75);
      end
    end
  endtask

  // one pass through the four idle patterns
  task automatic run_idle_patterns(input bit with_hold);
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      if (with_hold && k == 0) hold_cycles = 60;
      run_random(ITEMS_PER_SEGMENT);
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed cases at the reset settings (gain 5, coarse 10)
    send_sample(1, 0, 1, 4'hF, 0);    // idle pins, nothing changes
    send_sample(0, 0, 1, 4'hF, 1);    // fine detent up, first step
    send_sample(1, 0, 1, 4'hF, 1);    // rising CLK only relatches
    send_sample(0, 0, 0, 4'hF, 1);    // coarse detent up
    send_sample(1, 0, 0, 4'hF, 1);
    send_sample(1, 0, 1, 4'hF, 1);    // strobe with no pin change
    send_sample(0, 1, 1, 4'hF, 1);    // fine detent down
    send_sample(1, 1, 1, 4'hF, 0);
    send_sample(0, 1, 0, 4'hF, 1);    // coarse down to a zero target, position reverses
    send_sample(1, 1, 0, 4'hF, 1);    // still stepping down, phase reapplied
    send_sample(1, 1, 1, 4'hF, 1);
    send_sample(1, 1, 1, 4'hD, 1);    // mode 1, motor frozen
    send_sample(1, 1, 1, 4'hD, 1);    // held button, no new action
    send_sample(1, 1, 1, 4'hB, 1);    // mode 2
    send_sample(1, 1, 1, 4'h7, 1);    // mode 3
    send_sample(0, 0, 1, 4'h7, 1);    // detent while frozen
    send_sample(1, 0, 1, 4'hE, 1);    // clear back to run mode
    send_sample(0, 0, 0, 4'h0, 1);    // all buttons: clear then mode 3 wins
    send_sample(1, 1, 1, 4'hF, 1);    // release, all pins high
    send_sample(1, 1, 1, 4'hE, 0);    // clear alone
    send_sample(0, 0, 1, 4'hE, 1);
    send_sample(1, 1, 1, 4'hF, 1);
    run_idle_patterns(1'b1);
    settings_run++;

    // further settings: extremes, unity, then random values
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: begin write_reg(REG_TARGET_GAIN, 8'd0);   write_reg(REG_COARSE_INC, 8'd0);   end
        1: begin write_reg(REG_TARGET_GAIN, 8'd255); write_reg(REG_COARSE_INC, 8'd255); end
        2: begin write_reg(REG_TARGET_GAIN, 8'd1);   write_reg(REG_COARSE_INC, 8'd1);   end
        default: begin
          write_reg(REG_TARGET_GAIN, 8'($urandom_range(2, 12)));
          write_reg(REG_COARSE_INC, 8'($urandom_range(255)));
        end
      endcase
      run_idle_patterns(1'b0);
      settings_run++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.expected_states.size() != 0) begin
      tracker.mismatches++;
      $display("%0t: %0d results never arrived, expected none pending",
               $realtime, tracker.expected_states.size());
    end
    $display("Ran %0d pin samples over %0d register settings, %0d results compared.",
             items_sent, settings_run, tracker.checked);
    $display("Idle patterns on both streams and one long output hold-off were applied.");
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
